FILE: hw/rtl/four_class_priority_fifo_macros.svh
// Assertion macros for the four-class priority FIFO.
// Included by the top level; no other dependencies.
`ifndef FOUR_CLASS_PRIORITY_FIFO_MACROS_SVH
`define FOUR_CLASS_PRIORITY_FIFO_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FCPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcpq assertion failed");

// Next-cycle implication, disabled while in reset.
`define FCPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcpq assertion failed");

`endif

FILE: hw/rtl/fcpq_pkg.sv
// Shared types and constants for the four-class priority FIFO.
// No dependencies; used by the controller, datapath and top level.
package fcpq_pkg;

  localparam int unsigned NUM_CLASSES = 4;
  localparam int unsigned CLASS_W     = 2;
  localparam int unsigned TAG_W       = 16;
  localparam int unsigned AGE_W       = 8;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [AGE_W-1:0] AGE_THRESHOLD_RESET = 8'd60;

  localparam logic REQ_ENQ   = 1'b0;
  localparam logic REQ_SERVE = 1'b1;

  localparam logic [STATUS_W-1:0] STS_SERVED = 2'd0;
  localparam logic [STATUS_W-1:0] STS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture request beat
    logic push;    // write entry into its class
    logic reject;  // report full class
    logic empty;   // report all classes empty
    logic pop;     // read head of picked class
    logic emit;    // present popped entry
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_serve;
    logic cls_full;
    logic any_nonempty;
  } sts_t;

endpackage

FILE: hw/rtl/fcpq_ctrl.sv
// Controller state machine for the four-class priority FIFO.
// Depends on fcpq_pkg; drives the datapath through cmd_t, reads sts_t.
module fcpq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  fcpq_pkg::sts_t sts_i,
  output fcpq_pkg::cmd_t cmd_o
);
  import fcpq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.is_serve) begin
          if (sts_i.any_nonempty) begin
            cmd_o.pop = 1'b1;
            state_d   = S_POP;
          end else begin
            cmd_o.empty = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          if (sts_i.cls_full) begin
            cmd_o.reject = 1'b1;
          end else begin
            cmd_o.push = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        cmd_o.emit = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

FILE: hw/rtl/fcpq_dp.sv
// Datapath for the four-class priority FIFO: request capture, threshold
// register, class store memory, per-class pointers and counts, result regs.
// Depends on fcpq_pkg; commanded by fcpq_ctrl.
module fcpq_dp #(
  parameter int unsigned CLASS_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_type_i,
  input  logic [fcpq_pkg::TAG_W-1:0]        entry_tag_i,
  input  logic [fcpq_pkg::AGE_W-1:0]        entry_age_i,
  input  logic                              entry_flag_i,
  input  logic                              cfg_we_i,
  input  logic [fcpq_pkg::AGE_W-1:0]        cfg_wdata_i,
  input  fcpq_pkg::cmd_t                    cmd_i,
  output fcpq_pkg::sts_t                    sts_o,
  output logic                              done_o,
  output logic [fcpq_pkg::STATUS_W-1:0]     status_o,
  output logic [fcpq_pkg::TAG_W-1:0]        out_tag_o,
  output logic [fcpq_pkg::AGE_W-1:0]        out_age_o,
  output logic                              out_flag_o,
  output logic [fcpq_pkg::CLASS_W-1:0]      out_class_o
);
  import fcpq_pkg::*;

  localparam int unsigned PW    = $clog2(CLASS_DEPTH);
  localparam int unsigned CW    = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned AW    = CLASS_W + PW;
  localparam int unsigned SLOTS = NUM_CLASSES * (1 << PW);
  localparam int unsigned EW    = TAG_BITS + AGE_W + 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(CLASS_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(CLASS_DEPTH);

  // request beat
  logic                req_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [AGE_W-1:0]    age_q;
  logic                flag_q;
  logic [AGE_W-1:0]    thr_q;

  logic [TAG_BITS-1:0] tag_in;
  logic [TAG_W-1:0]    tag_out;

  logic [PW-1:0] head_q [NUM_CLASSES];
  logic [PW-1:0] tail_q [NUM_CLASSES];
  logic [CW-1:0] cnt_q  [NUM_CLASSES];

  logic [EW-1:0] mem_q [SLOTS];
  logic [EW-1:0] rd_q;

  logic [CLASS_W-1:0] enq_cls;
  logic [CLASS_W-1:0] pick_cls;
  logic [CLASS_W-1:0] pop_cls_q;
  logic               senior;
  logic               any_ne;

  logic                done_q;
  logic [STATUS_W-1:0] status_q;
  logic [TAG_W-1:0]    otag_q;
  logic [AGE_W-1:0]    oage_q;
  logic                oflag_q;
  logic [CLASS_W-1:0]  ocls_q;

  // tag resize in both directions
  for (genvar i = 0; i < TAG_BITS; i++) begin : g_tag_in
    if (i < TAG_W) begin : g_bit
      assign tag_in[i] = entry_tag_i[i];
    end else begin : g_zero
      assign tag_in[i] = 1'b0;
    end
  end
  for (genvar i = 0; i < TAG_W; i++) begin : g_tag_out
    if (i < TAG_BITS) begin : g_bit
      assign tag_out[i] = rd_q[AGE_W + 1 + i];
    end else begin : g_zero
      assign tag_out[i] = 1'b0;
    end
  end

  assign senior  = (age_q >= thr_q);
  assign enq_cls = {~flag_q, ~senior};

  always_comb begin
    pick_cls = CLASS_W'(3);
    any_ne   = 1'b1;
    priority if (cnt_q[0] != '0) begin
      pick_cls = CLASS_W'(0);
    end else if (cnt_q[1] != '0) begin
      pick_cls = CLASS_W'(1);
    end else if (cnt_q[2] != '0) begin
      pick_cls = CLASS_W'(2);
    end else if (cnt_q[3] != '0) begin
      pick_cls = CLASS_W'(3);
    end else begin
      any_ne = 1'b0;
    end
  end

  assign sts_o.is_serve     = (req_q == REQ_SERVE);
  assign sts_o.cls_full     = (cnt_q[enq_cls] == CNT_FULL);
  assign sts_o.any_nonempty = any_ne;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      tag_q  <= tag_in;
      age_q  <= entry_age_i;
      flag_q <= entry_flag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= AGE_THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // class store
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[{enq_cls, tail_q[enq_cls]}] <= {tag_q, age_q, flag_q};
    end
    if (cmd_i.pop) begin
      rd_q      <= mem_q[AW'({pick_cls, head_q[pick_cls]})];
      pop_cls_q <= pick_cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
    end else begin
      if (cmd_i.push) begin
        tail_q[enq_cls] <= (tail_q[enq_cls] == PTR_LAST) ? '0 : tail_q[enq_cls] + 1'b1;
        cnt_q[enq_cls]  <= cnt_q[enq_cls] + 1'b1;
      end
      if (cmd_i.pop) begin
        head_q[pick_cls] <= (head_q[pick_cls] == PTR_LAST) ? '0 : head_q[pick_cls] + 1'b1;
        cnt_q[pick_cls]  <= cnt_q[pick_cls] - 1'b1;
      end
    end
  end

  // result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.reject | cmd_i.empty | cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= STS_SERVED;
      otag_q   <= tag_out;
      oage_q   <= rd_q[AGE_W:1];
      oflag_q  <= rd_q[0];
      ocls_q   <= pop_cls_q;
    end else if (cmd_i.reject) begin
      status_q <= STS_FULL;
      otag_q   <= '0;
      oage_q   <= '0;
      oflag_q  <= 1'b0;
      ocls_q   <= enq_cls;
    end else if (cmd_i.empty) begin
      status_q <= STS_EMPTY;
      otag_q   <= '0;
      oage_q   <= '0;
      oflag_q  <= 1'b0;
      ocls_q   <= '0;
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign out_tag_o   = otag_q;
  assign out_age_o   = oage_q;
  assign out_flag_o  = oflag_q;
  assign out_class_o = ocls_q;

endmodule

FILE: hw/rtl/four_class_priority_fifo.sv
// Top level of the four-class strict-priority FIFO.
// Depends on fcpq_pkg, fcpq_ctrl, fcpq_dp and four_class_priority_fifo_macros.svh.
`include "four_class_priority_fifo_macros.svh"

// A request beat is taken when start is high and busy is low. An enqueue
// and a serve of an empty queue go from the idle state to the execute state;
// a serve that pops adds a pop state for the registered read of the class store.
// A result beat (rejected enqueue, empty, or served entry) appears on the
// output ports for one cycle with done_o high, in the cycle after the request
// finishes; the receiver must take it then, as there is no backpressure. A
// successful enqueue gives no result beat. The threshold may be written
// whenever busy is low and no result is pending.
module four_class_priority_fifo #(
  parameter int unsigned CLASS_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [fcpq_pkg::TAG_W-1:0]    entry_tag_i,
  input  logic [fcpq_pkg::AGE_W-1:0]    entry_age_i,
  input  logic                          entry_flag_i,
  input  logic                          cfg_we_i,
  input  logic [fcpq_pkg::AGE_W-1:0]    cfg_wdata_i,
  output logic                          done_o,
  output logic [fcpq_pkg::STATUS_W-1:0] status_o,
  output logic [fcpq_pkg::TAG_W-1:0]    out_tag_o,
  output logic [fcpq_pkg::AGE_W-1:0]    out_age_o,
  output logic                          out_flag_o,
  output logic [fcpq_pkg::CLASS_W-1:0]  out_class_o
);
  import fcpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fcpq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  fcpq_dp #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_type_i   (req_type_i),
    .entry_tag_i  (entry_tag_i),
    .entry_age_i  (entry_age_i),
    .entry_flag_i (entry_flag_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .done_o       (done_o),
    .status_o     (status_o),
    .out_tag_o    (out_tag_o),
    .out_age_o    (out_age_o),
    .out_flag_o   (out_flag_o),
    .out_class_o  (out_class_o)
  );

  `FCPQ_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `FCPQ_ASSERT_IMP(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy))
  `FCPQ_ASSERT_IMP(a_unserved_zero, clk_i, rst_ni, done_o && (status_o != STS_SERVED), (out_tag_o == '0) && (out_age_o == '0) && !out_flag_o)

endmodule
